[hdl/tbs_pkg.sv]
// Types and constants shared by the transport block size calculator.
package tbs_pkg;

    localparam int unsigned PROD_W = 28;
    localparam int unsigned SEG_W  = 29;
    localparam int unsigned Z_W    = 13;
    localparam int unsigned BLK_W  = 27;

    localparam logic [Z_W-1:0]    Z_RESET   = 13'd6144;
    localparam logic [BLK_W-1:0]  BLK_MAX   = 27'h7FF_FFFF;
    localparam logic [PROD_W-1:0] CRC_BITS  = 28'd24;
    localparam logic [PROD_W-1:0] THR_8     = 28'd512;
    localparam logic [PROD_W-1:0] THR_16    = 28'd1024;
    localparam logic [PROD_W-1:0] THR_32    = 28'd2048;

    typedef struct packed {
        logic [3:0]  spatial_streams;
        logic [15:0] data_subcarriers;
        logic [3:0]  bits_per_symbol;
        logic [3:0]  rate_numerator;
        logic [4:0]  rate_denominator;
    } tbs_fmt_t;

    typedef struct packed {
        logic [BLK_W-1:0] block_bits;
        logic             ill_configured;
    } tbs_res_t;

    typedef logic [Z_W-1:0] tbs_cfg_t;

    typedef struct packed {
        logic [PROD_W-1:0] n;
        logic              ill;
        logic              fits;
    } tbs_seg_t;

endpackage

[hdl/tbs_chan_if.sv]
// Valid/ready request channel carrying one payload.
interface tbs_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/tbs_div_cell.sv]
// One restoring division step with its own pipeline register and handshake.
module tbs_div_cell #(
    parameter int unsigned NW = 28,
    parameter int unsigned DW = 5,
    parameter int unsigned SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [DW-1:0] in_rem,
    input  logic [NW-1:0] in_dq,
    input  logic [DW-1:0] in_div,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [DW-1:0] out_rem,
    output logic [NW-1:0] out_dq,
    output logic [DW-1:0] out_div,
    output logic [SW-1:0] out_side
);

    logic          valid_reg;
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] dq_reg, dq_next;
    logic [DW-1:0] div_reg;
    logic [SW-1:0] side_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        trial    = {in_rem, in_dq[NW-1]};
        diff     = trial - {1'b0, in_div};
        ge       = trial >= {1'b0, in_div};
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        dq_next  = {in_dq[NW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg  <= rem_next;
            dq_reg   <= dq_next;
            div_reg  <= in_div;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_dq    = dq_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

[hdl/tbs_divider.sv]
// Pipelined divider: a chain of restoring cells, one quotient bit per cell.
module tbs_divider #(
    parameter int unsigned NW = 28,
    parameter int unsigned DW = 5,
    parameter int unsigned SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [NW-1:0] quotient,
    output logic [SW-1:0] out_side
);

    logic [NW:0]   v;
    logic [NW:0]   rdy;
    logic [DW-1:0] rem  [NW+1];
    logic [NW-1:0] dq   [NW+1];
    logic [DW-1:0] dvs  [NW+1];
    logic [SW-1:0] side [NW+1];

    assign v[0]    = in_valid;
    assign in_ready = rdy[0];
    assign rem[0]  = '0;
    assign dq[0]   = dividend;
    assign dvs[0]  = divisor;
    assign side[0] = in_side;

    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        tbs_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (v[i]),
            .in_ready (rdy[i]),
            .in_rem   (rem[i]),
            .in_dq    (dq[i]),
            .in_div   (dvs[i]),
            .in_side  (side[i]),
            .out_valid(v[i+1]),
            .out_ready(rdy[i+1]),
            .out_rem  (rem[i+1]),
            .out_dq   (dq[i+1]),
            .out_div  (dvs[i+1]),
            .out_side (side[i+1])
        );
    end

    assign rdy[NW]   = out_ready;
    assign out_valid = v[NW];
    assign quotient  = dq[NW];
    assign out_side  = side[NW];

endmodule

[hdl/transport_block_size_calc.sv]
// Transport block size calculator top level.
// Usage:
//   fmt : request channel of packet formats (streams, subcarriers, bits per
//         symbol, code rate numerator and denominator).
//   tbs : request channel of results (block_bits, ill_configured), one per
//         format, in order.
//   cfg : write channel for the code block size Z; always ready. Write only
//         while no format is in flight.
// Pipeline: three multiply stages, a 28-cell chain dividing by
// the rate denominator, a rounding stage, a 29-cell chain dividing by Z for
// the segment count, and the output register. One format is accepted per
// cycle when no stage is stalled. Every cell holds its own valid bit, so a
// stalled tbs receiver only backs up the cells that are full; empty cells keep
// taking requests until the chain is full, then fmt.ready drops.
// Reset empties the pipeline and sets Z to 6144.
module transport_block_size_calc (
    input logic clk,
    input logic rst_n,
    tbs_chan_if.sink   fmt,
    tbs_chan_if.source tbs,
    tbs_chan_if.sink   cfg
);

    logic [tbs_pkg::Z_W-1:0] z_reg;

    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic        rdy1, rdy2, rdy3, rdy4, rdy5, rdy_d1, rdy_d2;
    logic [19:0] a1_reg;
    logic [3:0]  bps1_reg, num1_reg, num2_reg;
    logic [4:0]  den1_reg, den2_reg, den3_reg;
    logic [23:0] b2_reg;
    logic [tbs_pkg::PROD_W-1:0] d3_reg;

    logic                        vd1;
    logic [tbs_pkg::PROD_W-1:0]  q1;
    logic                        den0_d1;

    logic [tbs_pkg::PROD_W-1:0]  n_next;
    logic [tbs_pkg::SEG_W-1:0]   dvd_next, dvd_reg;
    tbs_pkg::tbs_seg_t           seg_next, seg_reg;

    logic                        vd2;
    logic [tbs_pkg::SEG_W-1:0]   q2;
    tbs_pkg::tbs_seg_t           seg_d2;

    logic [tbs_pkg::SEG_W:0]     c1;
    logic [34:0]                 ov;
    logic [tbs_pkg::PROD_W-1:0]  diff;
    tbs_pkg::tbs_res_t           res_next, res_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_reg <= tbs_pkg::Z_RESET;
        end
        else if (cfg.valid)
        begin
            z_reg <= cfg.data;
        end
    end

    assign rdy1 = !v1_reg || rdy2;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy3 = !v3_reg || rdy_d1;
    assign rdy4 = !v4_reg || rdy_d2;
    assign rdy5 = !v5_reg || tbs.ready;
    assign fmt.ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= fmt.valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= vd1;
            if (rdy5) v5_reg <= vd2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && fmt.valid)
        begin
            a1_reg   <= 20'(fmt.data.spatial_streams) * 20'(fmt.data.data_subcarriers);
            bps1_reg <= fmt.data.bits_per_symbol;
            num1_reg <= fmt.data.rate_numerator;
            den1_reg <= fmt.data.rate_denominator;
        end
        if (rdy2 && v1_reg)
        begin
            b2_reg   <= 24'(a1_reg) * 24'(bps1_reg);
            num2_reg <= num1_reg;
            den2_reg <= den1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            d3_reg   <= tbs_pkg::PROD_W'(b2_reg) * tbs_pkg::PROD_W'(num2_reg);
            den3_reg <= den2_reg;
        end
    end

    // payload divide by rate denominator; a zero denominator is flagged on the side
    tbs_divider #(.NW(tbs_pkg::PROD_W), .DW(5), .SW(1)) u_div_rate (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v3_reg),
        .in_ready (rdy_d1),
        .dividend (d3_reg),
        .divisor  (den3_reg),
        .in_side  (den3_reg == 5'd0),
        .out_valid(vd1),
        .out_ready(rdy4),
        .quotient (q1),
        .out_side (den0_d1)
    );

    // round down, classify, and form ceil((n - 24) / z) dividend
    always_comb
    begin
        priority if (q1 <= tbs_pkg::THR_8)
            n_next = {q1[tbs_pkg::PROD_W-1:3], 3'b0};
        else if (q1 <= tbs_pkg::THR_16)
            n_next = {q1[tbs_pkg::PROD_W-1:4], 4'b0};
        else if (q1 <= tbs_pkg::THR_32)
            n_next = {q1[tbs_pkg::PROD_W-1:5], 5'b0};
        else
            n_next = {q1[tbs_pkg::PROD_W-1:6], 6'b0};
        seg_next.n    = n_next;
        seg_next.fits = n_next <= tbs_pkg::PROD_W'(z_reg);
        seg_next.ill  = den0_d1 || (n_next <= tbs_pkg::CRC_BITS)
                        || (!seg_next.fits && (z_reg == '0));
        dvd_next = {1'b0, n_next} - tbs_pkg::SEG_W'(tbs_pkg::CRC_BITS)
                   + tbs_pkg::SEG_W'(z_reg) - tbs_pkg::SEG_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && vd1)
        begin
            seg_reg <= seg_next;
            dvd_reg <= dvd_next;
        end
    end

    // segment count; a zero Z only reaches here already flagged ill
    tbs_divider #(
        .NW(tbs_pkg::SEG_W), .DW(tbs_pkg::Z_W), .SW($bits(tbs_pkg::tbs_seg_t))
    ) u_div_seg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v4_reg),
        .in_ready (rdy_d2),
        .dividend (dvd_reg),
        .divisor  (z_reg),
        .in_side  (seg_reg),
        .out_valid(vd2),
        .out_ready(rdy5),
        .quotient (q2),
        .out_side (seg_d2)
    );

    always_comb
    begin
        c1   = {1'b0, q2} + (tbs_pkg::SEG_W + 1)'(1);
        ov   = 35'({c1, 4'b0}) + 35'({c1, 3'b0});
        diff = '0;
        priority if (seg_d2.ill)
        begin
            res_next = '{block_bits: '0, ill_configured: 1'b1};
        end
        else if (seg_d2.fits)
        begin
            diff     = seg_d2.n - tbs_pkg::CRC_BITS;
            res_next = '{block_bits: diff[tbs_pkg::PROD_W-1] ? tbs_pkg::BLK_MAX
                                     : diff[tbs_pkg::BLK_W-1:0],
                         ill_configured: 1'b0};
        end
        else if (ov >= 35'(seg_d2.n))
        begin
            res_next = '{block_bits: '0, ill_configured: 1'b1};
        end
        else
        begin
            diff     = seg_d2.n - ov[tbs_pkg::PROD_W-1:0];
            res_next = '{block_bits: diff[tbs_pkg::PROD_W-1] ? tbs_pkg::BLK_MAX
                                     : diff[tbs_pkg::BLK_W-1:0],
                         ill_configured: 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy5 && vd2)
        begin
            res_reg <= res_next;
        end
    end

    assign tbs.valid = v5_reg;
    assign tbs.data  = res_reg;

`ifndef SYNTHESIS
    a_ill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg && res_reg.ill_configured |-> res_reg.block_bits == '0)
        else $error("ill configured result with nonzero size");

    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg && !res_reg.ill_configured |-> res_reg.block_bits != '0)
        else $error("valid result with zero size");
`endif

endmodule

[bench/tbs_bench_if.sv]
// Testbench constants for the transport block size calculator.
`timescale 1ns / 100ps
package tbs_bench_pkg;
    localparam int unsigned TB_LIMIT = 400000;
endpackage

[bench/transport_block_size_calc_tb.sv]
// Testbench for the transport block size calculator: random and directed formats.
`timescale 1ns / 100ps
module transport_block_size_calc_tb;

    logic clk;
    logic rst_n;

    tbs_chan_if #(.T(tbs_pkg::tbs_fmt_t)) fmt ();
    tbs_chan_if #(.T(tbs_pkg::tbs_res_t)) tbs ();
    tbs_chan_if #(.T(tbs_pkg::tbs_cfg_t)) cfg ();

    transport_block_size_calc u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .fmt   (fmt),
        .tbs   (tbs),
        .cfg   (cfg)
    );

    tbs_pkg::tbs_fmt_t fmt_queue[$];
    tbs_pkg::tbs_res_t size_queue[$];
    logic [12:0] cur_z;
    int errors;
    int cycles;
    int gap;
    int stall;
    bit hold;
    bit fmt_taken;

    function automatic tbs_pkg::tbs_res_t calc_size(tbs_pkg::tbs_fmt_t f, logic [12:0] z);
        tbs_pkg::tbs_res_t r;
        logic [63:0] g;
        logic [63:0] p;
        logic [63:0] m;
        logic [63:0] n;
        logic [63:0] c;
        logic [63:0] ovh;
        logic [63:0] b;
        r.block_bits = '0;
        r.ill_configured = 1'b1;
        if (f.rate_denominator == 5'd0)
            return r;
        g = 64'(f.spatial_streams) * 64'(f.data_subcarriers) * 64'(f.bits_per_symbol);
        p = (g * 64'(f.rate_numerator)) / 64'(f.rate_denominator);
        m = (p <= 64'd512) ? 64'd8 : (p <= 64'd1024) ? 64'd16 : (p <= 64'd2048) ? 64'd32 : 64'd64;
        n = (p / m) * m;
        if (n <= 64'd24)
            return r;
        if (n <= 64'(z))
            b = n - 64'd24;
        else
        begin
            if (z == 13'd0)
                return r;
            c = (n - 64'd24 + 64'(z) - 64'd1) / 64'(z);
            ovh = (c + 64'd1) * 64'd24;
            if (ovh >= n)
                return r;
            b = n - ovh;
        end
        if (b > 64'(tbs_pkg::BLK_MAX))
            b = 64'(tbs_pkg::BLK_MAX);
        r.block_bits = b[26:0];
        r.ill_configured = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // driver
    always @(negedge clk)
    begin
        if (fmt_taken)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30) :
                  ($urandom_range(0, 2) == 0 ? $urandom_range(0, 2) : 0);
        else if (!fmt.valid && gap > 0)
            gap--;
        if (!fmt.valid || fmt_taken)
        begin
            if (fmt_queue.size() > 0 && gap == 0 && !hold && rst_n)
            begin
                fmt.valid <= 1'b1;
                fmt.data <= fmt_queue[0];
            end
            else
                fmt.valid <= 1'b0;
        end
        if (stall > 0)
        begin
            stall--;
            tbs.ready <= 1'b0;
        end
        else
        begin
            tbs.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cycles++;
        fmt_taken = fmt.valid && fmt.ready;
        if (fmt_taken)
        begin
            size_queue.push_back(calc_size(fmt.data, cur_z));
            void'(fmt_queue.pop_front());
        end
        if (tbs.valid && tbs.ready)
        begin
            if (size_queue.size() == 0)
                report_mismatch("unexpected result", int'(tbs.data.block_bits), -1);
            else
            begin
                if (tbs.data.block_bits !== size_queue[0].block_bits)
                    report_mismatch("block_bits", int'(tbs.data.block_bits),
                                    int'(size_queue[0].block_bits));
                if (tbs.data.ill_configured !== size_queue[0].ill_configured)
                    report_mismatch("ill_configured", int'(tbs.data.ill_configured),
                                    int'(size_queue[0].ill_configured));
                void'(size_queue.pop_front());
            end
        end
        if (cycles > int'(tbs_bench_pkg::TB_LIMIT))
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic tbs_pkg::tbs_fmt_t rand_fmt(bit wide);
        tbs_pkg::tbs_fmt_t f;
        f.spatial_streams = wide ? 4'($urandom) : 4'($urandom_range(1, 8));
        f.data_subcarriers = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 40)) :
                             16'($urandom);
        f.bits_per_symbol = wide ? 4'($urandom) : 4'($urandom_range(1, 12));
        f.rate_numerator = 4'($urandom);
        f.rate_denominator = wide ? 5'($urandom) : 5'($urandom_range(1, 16));
        return f;
    endfunction

    task automatic push_fmt(int ss, int sc, int bps, int num, int den);
        tbs_pkg::tbs_fmt_t f;
        f = '{4'(ss), 16'(sc), 4'(bps), 4'(num), 5'(den)};
        fmt_queue.push_back(f);
    endtask

    task automatic drain();
        while (fmt_queue.size() > 0 || fmt.valid || size_queue.size() > 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic write_z(logic [12:0] z);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.data <= z;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cur_z = z;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        logic [12:0] zs[6];
        rst_n = 1'b0;
        fmt.valid = 1'b0;
        fmt.data = '0;
        tbs.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        cur_z = tbs_pkg::Z_RESET;
        errors = 0;
        cycles = 0;
        gap = 0;
        stall = 0;
        hold = 0;
        fmt_taken = 0;
        zs = '{13'd256, 13'd8191, 13'd0, 13'd1, 13'd24, 13'd1000};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // directed: extremes, zero denominator, small payload, thresholds, saturation
        push_fmt(1, 0, 1, 1, 1);
        push_fmt(8, 65535, 12, 15, 1);
        push_fmt(15, 65535, 15, 15, 1);
        push_fmt(1, 100, 1, 1, 0);
        push_fmt(1, 24, 1, 1, 1);
        push_fmt(1, 25, 1, 1, 1);
        push_fmt(1, 32, 1, 1, 1);
        push_fmt(1, 512, 1, 1, 1);
        push_fmt(1, 527, 1, 1, 1);
        push_fmt(1, 1024, 1, 1, 1);
        push_fmt(1, 1055, 1, 1, 1);
        push_fmt(1, 2048, 1, 1, 1);
        push_fmt(1, 2111, 1, 1, 1);
        push_fmt(1, 6144, 1, 1, 1);
        push_fmt(1, 6208, 1, 1, 1);
        push_fmt(8, 40000, 12, 7, 16);
        push_fmt(1, 1000, 1, 15, 31);
        drain();
        for (int ph = 0; ph < 7; ph++)
        begin
            for (int i = 0; i < 110; i++)
                fmt_queue.push_back(rand_fmt($urandom_range(0, 4) == 0));
            if (ph == 2)
            begin
                while (fmt_queue.size() > 55)
                    @(posedge clk);
                hold = 1;
                while (size_queue.size() > 0 || fmt.valid)
                    @(posedge clk);
                hold = 0;
            end
            drain();
            if (ph < 6)
                write_z(zs[ph]);
        end
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
